// ===== hw/rtl/cau_pkg.sv =====
package cau_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 4;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT = 2'd2;

   typedef struct packed {
      action_type action;
      logic signed [DATA_WIDTH-1:0] a_real;
      logic signed [DATA_WIDTH-1:0] a_imag;
      logic signed [DATA_WIDTH-1:0] b_real;
      logic signed [DATA_WIDTH-1:0] b_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] res_real;
      logic signed [DATA_WIDTH-1:0] res_imag;
      logic [1:0] status;
   } rsp_type;

   // queued transaction with its class
   typedef struct packed {
      req_type req;
      logic div_zero;
   } qent_type;

endpackage

// ===== hw/rtl/cau_front.sv =====
module cau_front #(
   parameter int DEPTH = 4
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input cau_pkg::req_type req_item,
   output logic q_valid,
   output cau_pkg::qent_type q_head,
   input logic q_pop
);
   import cau_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qent_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic push;
   qent_type ent;

   assign busy = (count_ff == CW'(DEPTH));
   assign push = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_head = mem_ff[rd_ptr_ff];

   always_comb begin
      ent.req = req_item;
      ent.div_zero = (req_item.action == ACT_DIV) && (req_item.b_real == '0)
                     && (req_item.b_imag == '0);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= ent;
      end
   end

endmodule

// ===== hw/rtl/cau_back.sv =====
module cau_back #(
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input cau_pkg::qent_type q_head,
   output logic q_pop,
   output logic rsp_strobe,
   output cau_pkg::rsp_type rsp_item
);
   import cau_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int PWD = 2 * DW;
   localparam int VW = PWD + 1;
   localparam int RW = PWD + 1;
   localparam int NB = VW + FRAC_BITS;
   localparam int SW = NB + 1;
   localparam int KW = $clog2(NB + 1);

   function automatic logic [DW:0] sat_f(input logic [SW-1:0] m, input logic neg);
      logic [SW-1:0] maxpos;
      logic [DW-1:0] low;
      maxpos = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
      low = m[DW-1:0];
      if (!neg) begin
         if (m > maxpos) return {1'b1, 1'b0, {(DW-1){1'b1}}};
         return {1'b0, low};
      end
      if (m > maxpos + 1'b1) return {1'b1, 1'b1, {(DW-1){1'b0}}};
      return {1'b0, -low};
   endfunction

   // stage 1 registers
   logic s1_valid_ff;
   action_type s1_act_ff;
   logic s1_zero_ff;
   logic signed [DW:0] s1_sr_ff, s1_si_ff, s1_sr_in, s1_si_in;
   logic signed [PWD-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff, p_br_ff, p_bi_ff;

   // divider
   logic div_busy_ff;
   logic [KW-1:0] cnt_ff;
   logic [NB-1:0] num_r_ff, num_i_ff, q_r_ff, q_i_ff;
   logic [RW-1:0] rem_r_ff, rem_i_ff, den_ff;
   logic neg_r_ff, neg_i_ff;

   logic rsp_strobe_ff;
   rsp_type rsp_ff;

   logic stall;
   assign stall = div_busy_ff;
   assign q_pop = q_valid && !stall;

   req_type h;
   assign h = q_head.req;

   always_comb begin
      if (h.action == ACT_SUB) begin
         s1_sr_in = {h.a_real[DW-1], h.a_real} - {h.b_real[DW-1], h.b_real};
         s1_si_in = {h.a_imag[DW-1], h.a_imag} - {h.b_imag[DW-1], h.b_imag};
      end else begin
         s1_sr_in = {h.a_real[DW-1], h.a_real} + {h.b_real[DW-1], h.b_real};
         s1_si_in = {h.a_imag[DW-1], h.a_imag} + {h.b_imag[DW-1], h.b_imag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_act_ff <= h.action;
         s1_zero_ff <= q_head.div_zero;
         s1_sr_ff <= s1_sr_in;
         s1_si_ff <= s1_si_in;
         p_rr_ff <= h.a_real * h.b_real;
         p_ii_ff <= h.a_imag * h.b_imag;
         p_ir_ff <= h.a_imag * h.b_real;
         p_ri_ff <= h.a_real * h.b_imag;
         p_br_ff <= h.b_real * h.b_real;
         p_bi_ff <= h.b_imag * h.b_imag;
      end
   end

   // stage 2: combine, round, saturate
   logic signed [VW-1:0] vr, vi;
   logic [VW-1:0] mr, mi;
   logic [SW-1:0] rr_mag, ri_mag, half;
   logic [DW:0] sr, si;
   logic s2_out, s2_div;
   rsp_type s2_rsp;
   logic [RW-1:0] den;

   always_comb begin
      half = {{(SW-1){1'b0}}, 1'b1} << FRAC_BITS >> 1;
      den = {1'b0, p_br_ff} + {1'b0, p_bi_ff};
      if (s1_act_ff == ACT_MUL) begin
         vr = {p_rr_ff[PWD-1], p_rr_ff} - {p_ii_ff[PWD-1], p_ii_ff};
         vi = {p_ir_ff[PWD-1], p_ir_ff} + {p_ri_ff[PWD-1], p_ri_ff};
      end else begin
         vr = {p_rr_ff[PWD-1], p_rr_ff} + {p_ii_ff[PWD-1], p_ii_ff};
         vi = {p_ir_ff[PWD-1], p_ir_ff} - {p_ri_ff[PWD-1], p_ri_ff};
      end
      mr = vr[VW-1] ? -vr : vr;
      mi = vi[VW-1] ? -vi : vi;
      if (s1_act_ff == ACT_MUL) begin
         rr_mag = ({{(SW-VW){1'b0}}, mr} + half) >> FRAC_BITS;
         ri_mag = ({{(SW-VW){1'b0}}, mi} + half) >> FRAC_BITS;
         sr = sat_f(rr_mag, vr[VW-1]);
         si = sat_f(ri_mag, vi[VW-1]);
      end else begin
         rr_mag = SW'(s1_sr_ff[DW] ? -s1_sr_ff : s1_sr_ff);
         ri_mag = SW'(s1_si_ff[DW] ? -s1_si_ff : s1_si_ff);
         rr_mag[SW-1:DW+1] = '0;
         ri_mag[SW-1:DW+1] = '0;
         sr = sat_f(rr_mag, s1_sr_ff[DW]);
         si = sat_f(ri_mag, s1_si_ff[DW]);
      end
      s2_rsp.res_real = sr[DW-1:0];
      s2_rsp.res_imag = si[DW-1:0];
      s2_rsp.status = (sr[DW] || si[DW]) ? ST_SAT : ST_OK;
      if (s1_act_ff == ACT_DIV && s1_zero_ff) begin
         s2_rsp.res_real = '0;
         s2_rsp.res_imag = '0;
         s2_rsp.status = ST_DIV_ZERO;
      end
      s2_div = s1_valid_ff && !stall && (s1_act_ff == ACT_DIV) && !s1_zero_ff;
      s2_out = s1_valid_ff && !stall && !s2_div;
   end

   // restoring divider, one quotient bit of each part per cycle
   logic [RW-1:0] sh_r, sh_i;
   logic ge_r, ge_i, up_r, up_i;
   logic [SW-1:0] qr_mag, qi_mag;
   logic [DW:0] dr, di;
   rsp_type div_rsp;

   always_comb begin
      sh_r = {rem_r_ff[RW-2:0], num_r_ff[NB-1]};
      sh_i = {rem_i_ff[RW-2:0], num_i_ff[NB-1]};
      ge_r = (sh_r >= den_ff);
      ge_i = (sh_i >= den_ff);
      up_r = ({rem_r_ff, 1'b0} >= {1'b0, den_ff});
      up_i = ({rem_i_ff, 1'b0} >= {1'b0, den_ff});
      qr_mag = {1'b0, q_r_ff} + SW'(up_r);
      qi_mag = {1'b0, q_i_ff} + SW'(up_i);
      dr = sat_f(qr_mag, neg_r_ff);
      di = sat_f(qi_mag, neg_i_ff);
      div_rsp.res_real = dr[DW-1:0];
      div_rsp.res_imag = di[DW-1:0];
      div_rsp.status = (dr[DW] || di[DW]) ? ST_SAT : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (s2_div) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && cnt_ff == '0) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_div) begin
         cnt_ff <= KW'(NB);
         num_r_ff <= {mr, {FRAC_BITS{1'b0}}};
         num_i_ff <= {mi, {FRAC_BITS{1'b0}}};
         neg_r_ff <= vr[VW-1];
         neg_i_ff <= vi[VW-1];
         den_ff <= den;
         rem_r_ff <= '0;
         rem_i_ff <= '0;
         q_r_ff <= '0;
         q_i_ff <= '0;
      end else if (div_busy_ff && cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
         num_r_ff <= num_r_ff << 1;
         num_i_ff <= num_i_ff << 1;
         rem_r_ff <= ge_r ? sh_r - den_ff : sh_r;
         rem_i_ff <= ge_i ? sh_i - den_ff : sh_i;
         q_r_ff <= {q_r_ff[NB-2:0], ge_r};
         q_i_ff <= {q_i_ff[NB-2:0], ge_i};
      end
   end

   logic div_done;
   assign div_done = div_busy_ff && (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s2_out || div_done;
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         rsp_ff <= div_rsp;
      end else if (s2_out) begin
         rsp_ff <= s2_rsp;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// complex add, subtract, multiply and divide on signed q16.16 operand pairs.
// request: a transaction is taken on a clock edge with start high and busy low;
//   busy is high only while the input queue is full.
// response: rsp_strobe is high for one cycle with rsp_item valid; there is
//   no backpressure, so results must be taken when shown.
// path: after acceptance, add, subtract, multiply and divide by zero pass
//   through the queue, the product stage and the round/saturate stage.
// throughput: one transaction per cycle for add, subtract and multiply while the divider is idle.
// divide runs a restoring divider, one quotient bit of each part per cycle,
//   with FRAC_BITS fraction bits in the quotient (q16.16 by default); meanwhile
//   the back end holds and the queue fills; the front keeps taking
//   transactions until the queue is full.
// status: ok, divide by zero (parts forced to zero) or saturated.
// reset: synchronous, empties the queue and drops any work in flight.
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = cau_pkg::QUEUE_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input cau_pkg::req_type req_item,
   output logic rsp_strobe,
   output cau_pkg::rsp_type rsp_item
);
   import cau_pkg::*;

   logic q_valid, q_pop;
   qent_type q_head;

   cau_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .q_valid(q_valid),
      .q_head(q_head),
      .q_pop(q_pop)
   );

   cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_head(q_head),
      .q_pop(q_pop),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

`ifndef NO_ASSERTIONS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.status == ST_OK || rsp_item.status == ST_DIV_ZERO
                      || rsp_item.status == ST_SAT))
      else $error("bad status code");

   a_div_zero_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == ST_DIV_ZERO |->
         rsp_item.res_real == '0 && rsp_item.res_imag == '0)
      else $error("divide by zero with nonzero result");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == ST_SAT |->
         (rsp_item.res_real == {1'b0, {(DATA_WIDTH-1){1'b1}}}
          || rsp_item.res_real == {1'b1, {(DATA_WIDTH-1){1'b0}}}
          || rsp_item.res_imag == {1'b0, {(DATA_WIDTH-1){1'b1}}}
          || rsp_item.res_imag == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
      else $error("saturated status without clamped part");
`endif

endmodule

// ===== dv/complex_arithmetic_unit_check.sv =====
`timescale 1ns / 100ps

module complex_arithmetic_unit_check (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input cau_pkg::req_type req_item,
   input logic rsp_strobe,
   input cau_pkg::rsp_type rsp_item,
   output int fail_count,
   output int pending
);
   import cau_pkg::*;

   localparam int QF = FRAC_BITS_DEF;

   rsp_type expected_results[$];

   // round to nearest q value, ties away from zero
   function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
      logic [127:0] mag;
      mag = v < 0 ? -v : v;
      mag = (mag + (128'd1 << (QF - 1))) >> QF;
      return v < 0 ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [127:0] divide_q(input logic signed [127:0] n,
                                                    input logic [127:0] d);
      logic [127:0] num, quo, rm;
      num = (n < 0 ? -n : n) << QF;
      quo = num / d;
      rm = num % d;
      if (rm * 2 >= d) quo = quo + 1;
      return n < 0 ? -$signed(quo) : $signed(quo);
   endfunction

   function automatic logic [DATA_WIDTH-1:0] clamp_q(input logic signed [127:0] v,
                                                     inout logic sat);
      if (v > 128'sh7fffffff) begin
         sat = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -128'sh80000000) begin
         sat = 1'b1;
         return 32'h80000000;
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   function automatic rsp_type complex_result(input req_type r);
      logic signed [127:0] ar, ai, br, bi, re, im;
      logic [127:0] den;
      logic sat;
      rsp_type o;
      ar = r.a_real;
      ai = r.a_imag;
      br = r.b_real;
      bi = r.b_imag;
      sat = 1'b0;
      case (r.action)
         ACT_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         ACT_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         ACT_MUL: begin
            re = round_q(ar * br - ai * bi);
            im = round_q(ai * br + ar * bi);
         end
         default: begin
            if (br == 0 && bi == 0) begin
               o.res_real = '0;
               o.res_imag = '0;
               o.status = ST_DIV_ZERO;
               return o;
            end
            den = br * br + bi * bi;
            re = divide_q(ar * br + ai * bi, den);
            im = divide_q(ai * br - ar * bi, den);
         end
      endcase
      o.res_real = clamp_q(re, sat);
      o.res_imag = clamp_q(im, sat);
      o.status = sat ? ST_SAT : ST_OK;
      return o;
   endfunction

   initial fail_count = 0;
   assign pending = expected_results.size();

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) expected_results.push_back(complex_result(req_item));
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.res_real !== want.res_real) begin
                  $error("res_real expected %h actual %h", want.res_real, rsp_item.res_real);
                  fail_count++;
               end
               if (rsp_item.res_imag !== want.res_imag) begin
                  $error("res_imag expected %h actual %h", want.res_imag, rsp_item.res_imag);
                  fail_count++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_item.status);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ===== dv/complex_arithmetic_unit_test.sv =====
`timescale 1ns / 100ps

module complex_arithmetic_unit_test;
   import cau_pkg::*;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_item;
   logic rsp_strobe;
   rsp_type rsp_item;
   int fail_count;
   int pending;
   int idle_pct;

   complex_arithmetic_unit i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   complex_arithmetic_unit_check i_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("complex_arithmetic_unit_test NOT OK");
      $finish;
   end

   // leaves start high after acceptance; idle gaps lower it inside the task, and the caller lowers it when done
   task automatic send_transaction(input req_type r);
      int gap;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [31:0] pick_part();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(0, 8) ? $urandom_range(0, 3) << 16 : 32'h8000_0000;
         2: return -($urandom_range(0, 3) << 16);
         3: return $urandom_range(0, 255) - 128;
         4: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
         default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
   endfunction

   task automatic send_parts(input action_type op, input logic [31:0] ar, ai, br, bi);
      req_type r;
      r.action = op;
      r.a_real = ar;
      r.a_imag = ai;
      r.b_real = br;
      r.b_imag = bi;
      send_transaction(r);
   endtask

   initial begin
      req_type r;
      action_type op;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      idle_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, saturation, rounding ties, divide by zero
      send_parts(ACT_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_parts(ACT_ADD, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00000001);
      send_parts(ACT_SUB, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'hffffffff);
      send_parts(ACT_SUB, 32'h00030000, 32'h0, 32'h00010000, 32'h0);
      send_parts(ACT_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_parts(ACT_MUL, 32'h00008000, 32'h0, 32'h00000001, 32'h0);
      send_parts(ACT_MUL, 32'hffff8000, 32'h0, 32'h00000001, 32'h0);
      send_parts(ACT_MUL, 32'h00018000, 32'h00020000, 32'hfffe0000, 32'h00010000);
      send_parts(ACT_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_parts(ACT_DIV, 32'h00010000, 32'h00020000, 32'h0, 32'h0);
      send_parts(ACT_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
      send_parts(ACT_DIV, 32'h00010000, 32'h0, 32'h00030000, 32'h0);
      send_parts(ACT_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0);
      send_parts(ACT_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_parts(ACT_DIV, 32'h00000001, 32'h0, 32'h0, 32'h00020000);
      send_parts(ACT_DIV, 32'hffff0000, 32'h00050000, 32'hfffe0000, 32'h00010000);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = phase == 1 ? 60 : phase == 2 ? 38 : 0;
         for (int n = 0; n < 235; n++) begin
            op = action_type'($urandom_range(3));
            r.action = op;
            r.a_real = pick_part();
            r.a_imag = pick_part();
            r.b_real = pick_part();
            r.b_imag = pick_part();
            if (op == ACT_DIV && $urandom_range(15) == 0) begin
               r.b_real = '0;
               r.b_imag = '0;
            end
            send_transaction(r);
         end
         // clear idling after phase 1; the next phase sets idle_pct again at its start
         if (phase == 1) idle_pct = 0;
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("complex_arithmetic_unit_test OK");
      end else begin
         $display("complex_arithmetic_unit_test NOT OK");
      end
      $finish;
   end

endmodule
